// ===== design/rspa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Pool sizes, derived widths, request and status codes, and the request and
// result records shared by the front end, the engine and the top level.
// ----------------------------------------------------------------------------
package rspa_pkg;

    localparam int SMALL_SLOTS  = 64;
    localparam int MEDIUM_SLOTS = 32;
    localparam int COUNT_BITS   = 8;

    // slots examined per scan cycle
    localparam int LANES        = 8;

    localparam int SLOT_PORT_W  = 6;
    localparam int COUNT_PORT_W = 8;
    localparam int DROP_W       = 32;

    localparam int MAX_SLOTS    = (SMALL_SLOTS > MEDIUM_SLOTS) ? SMALL_SLOTS : MEDIUM_SLOTS;
    localparam int TOTAL_SLOTS  = SMALL_SLOTS + MEDIUM_SLOTS;
    localparam int ADDR_W       = $clog2(TOTAL_SLOTS);
    localparam int IDX_W        = $clog2(MAX_SLOTS);
    localparam int POS_W        = $clog2(MAX_SLOTS + LANES) + 1;
    localparam int RANGE_W      = ($clog2(MAX_SLOTS + 1) > SLOT_PORT_W) ?
                                  $clog2(MAX_SLOTS + 1) : SLOT_PORT_W;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RETAIN  = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_FREE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXHAUST = 3'd1,
        ST_RANGE   = 3'd2,
        ST_UNDER   = 3'd3,
        ST_SAT     = 3'd4
    } t_status;

    typedef struct packed {
        t_req                   req;
        logic                   pool;
        logic [SLOT_PORT_W-1:0] slot;
        logic                   bad_range;
    } t_cmd;

    typedef struct packed {
        t_status                 status;
        logic                    pool;
        logic [SLOT_PORT_W-1:0]  slot;
        logic [COUNT_PORT_W-1:0] count;
        logic                    freed;
        logic [DROP_W-1:0]       drop;
    } t_res;

endpackage
`default_nettype wire

// ===== design/rspa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool allocator front end
// Accepts requests, decodes the request type, checks the slot index against
// the addressed pool and holds decoded requests in a two-entry queue.
// ----------------------------------------------------------------------------
module rspa_front
    import rspa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic [1:0]             i_req_type,
    input  wire logic                   i_pool_select,
    input  wire logic [SLOT_PORT_W-1:0] i_slot_number,
    output logic                        o_cmd_valid,
    output t_cmd                        o_cmd,
    input  wire logic                   i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push_ok, w_pop_ok;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.req       = t_req'(i_req_type);
        w_cmd.pool      = i_pool_select;
        w_cmd.slot      = i_slot_number;
        w_cmd.bad_range = (w_cmd.req != REQ_ALLOC) &&
                          (RANGE_W'(i_slot_number) >= (i_pool_select ?
                              RANGE_W'(MEDIUM_SLOTS) : RANGE_W'(SMALL_SLOTS)));
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push_ok   = i_push && !o_full;
    assign w_pop_ok    = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/rspa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool allocator engine
// Runs decoded requests: next-fit scan over the in-use bits for allocation,
// read-modify-write of the count memory for addressed requests, and a
// saturating drop counter. Holds a pending result and the output register.
// ----------------------------------------------------------------------------
module rspa_back
    import rspa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_pop
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state                 r_state, n_state;
    logic                   r_pool, n_pool;
    logic [POS_W-1:0]       r_off, n_off;
    logic [POS_W-1:0]       r_start, n_start;
    t_req                   r_req, n_req;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [IDX_W-1:0]       r_cur_s, n_cur_s;
    logic [IDX_W-1:0]       r_cur_m, n_cur_m;
    logic [DROP_W-1:0]      r_drop, n_drop;
    logic [TOTAL_SLOTS-1:0] r_busy, n_busy;
    t_res                   r_pend, n_pend;
    t_res                   r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    // count memory; an entry whose in-use bit is clear reads as zero
    logic [COUNT_BITS-1:0]  mem [TOTAL_SLOTS];
    logic [COUNT_BITS-1:0]  r_rd;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr, w_raddr;
    logic [COUNT_BITS-1:0]  w_wdata;

    // scan lanes
    logic [POS_W-1:0]       w_size;
    logic [ADDR_W-1:0]      w_base;
    logic [POS_W-1:0]       w_lane_off [LANES];
    logic [POS_W-1:0]       w_lane_pos [LANES];
    logic [ADDR_W-1:0]      w_lane_addr [LANES];
    logic                   w_found, w_last;
    logic [POS_W-1:0]       w_hit_pos, w_hit_nxt;
    logic [ADDR_W-1:0]      w_hit_addr;
    logic [POS_W:0]         w_off_end;

    // addressed update
    logic [COUNT_BITS-1:0]  w_cur, w_new;
    t_status                w_st;
    logic                   w_freed;

    assign w_size = r_pool ? POS_W'(MEDIUM_SLOTS) : POS_W'(SMALL_SLOTS);
    assign w_base = r_pool ? ADDR_W'(SMALL_SLOTS) : '0;

    always_comb begin
        w_found    = 1'b0;
        w_hit_pos  = '0;
        w_hit_addr = '0;
        // walk lanes from the top so the lowest free lane wins
        for (int j = LANES - 1; j >= 0; j--) begin
            w_lane_off[j]  = r_off + POS_W'(j);
            w_lane_pos[j]  = r_start + w_lane_off[j];
            if (w_lane_pos[j] >= w_size) begin
                w_lane_pos[j] = w_lane_pos[j] - w_size;
            end
            w_lane_addr[j] = w_base + ADDR_W'(w_lane_pos[j]);
            if ((w_lane_off[j] < w_size) && !r_busy[w_lane_addr[j]]) begin
                w_found    = 1'b1;
                w_hit_pos  = w_lane_pos[j];
                w_hit_addr = w_lane_addr[j];
            end
        end
        w_off_end = {1'b0, r_off} + (POS_W + 1)'(LANES);
        w_last    = (w_off_end >= {1'b0, w_size});
        w_hit_nxt = w_hit_pos + POS_W'(1);
        if (w_hit_nxt == w_size) begin
            w_hit_nxt = '0;
        end
    end

    always_comb begin
        w_cur   = r_busy[r_addr] ? r_rd : '0;
        w_new   = w_cur;
        w_st    = ST_OK;
        w_freed = 1'b0;
        case (r_req)
            REQ_RETAIN: begin
                if (w_cur == COUNT_MAX) begin
                    w_st = ST_SAT;
                end else begin
                    w_new = w_cur + COUNT_BITS'(1);
                end
            end
            REQ_RELEASE: begin
                if (w_cur == '0) begin
                    w_st = ST_UNDER;
                end else begin
                    w_new   = w_cur - COUNT_BITS'(1);
                    w_freed = (w_new == '0);
                end
            end
            REQ_FREE: begin
                w_new   = '0;
                w_freed = (w_cur != '0);
            end
            default: begin
                w_new = w_cur;
            end
        endcase
    end

    assign w_raddr = (i_cmd.pool ? ADDR_W'(SMALL_SLOTS) : '0) + ADDR_W'(i_cmd.slot);

    always_comb begin
        n_state     = r_state;
        n_pool      = r_pool;
        n_off       = r_off;
        n_start     = r_start;
        n_req       = r_req;
        n_addr      = r_addr;
        n_slot      = r_slot;
        n_cur_s     = r_cur_s;
        n_cur_m     = r_cur_m;
        n_drop      = r_drop;
        n_busy      = r_busy;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = '0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.req == REQ_ALLOC) begin
                        n_pool  = 1'b0;
                        n_off   = '0;
                        n_start = POS_W'(r_cur_s);
                        n_state = S_SCAN;
                    end else if (i_cmd.bad_range) begin
                        n_pend  = '{ST_RANGE, i_cmd.pool, i_cmd.slot,
                                    '0, 1'b0, r_drop};
                        n_state = S_DONE;
                    end else begin
                        n_req   = i_cmd.req;
                        n_pool  = i_cmd.pool;
                        n_addr  = w_raddr;
                        n_slot  = IDX_W'(i_cmd.slot);
                        n_state = S_UPD;
                    end
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    w_we               = 1'b1;
                    w_waddr            = w_hit_addr;
                    w_wdata            = COUNT_BITS'(1);
                    n_busy[w_hit_addr] = 1'b1;
                    if (r_pool) begin
                        n_cur_m = IDX_W'(w_hit_nxt);
                    end else begin
                        n_cur_s = IDX_W'(w_hit_nxt);
                    end
                    n_pend  = '{ST_OK, r_pool, SLOT_PORT_W'(w_hit_pos),
                                COUNT_PORT_W'(1), 1'b0, r_drop};
                    n_state = S_DONE;
                end else if (w_last) begin
                    if (!r_pool) begin
                        // small pool full: move on to the medium pool
                        n_pool  = 1'b1;
                        n_off   = '0;
                        n_start = POS_W'(r_cur_m);
                    end else begin
                        n_drop  = (r_drop == '1) ? r_drop : r_drop + DROP_W'(1);
                        n_pend  = '{ST_EXHAUST, 1'b0, '0, '0, 1'b0, n_drop};
                        n_state = S_DONE;
                    end
                end else begin
                    n_off = r_off + POS_W'(LANES);
                end
            end
            S_UPD: begin
                w_we           = 1'b1;
                w_waddr        = r_addr;
                w_wdata        = w_new;
                n_busy[r_addr] = (w_new != '0);
                n_pend         = '{w_st, r_pool, SLOT_PORT_W'(r_slot),
                                   COUNT_PORT_W'(w_new), w_freed, r_drop};
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_s     <= '0;
            r_cur_m     <= '0;
            r_drop      <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_s     <= n_cur_s;
            r_cur_m     <= n_cur_m;
            r_drop      <= n_drop;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_pool  <= n_pool;
        r_off   <= n_off;
        r_start <= n_start;
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_slot  <= n_slot;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_grant_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_found) |=> r_busy[$past(w_hit_addr)])
        else $error("granted slot not marked in use");

    a_drop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_found && w_last && r_pool && r_drop != '1)
        |=> (r_drop == $past(r_drop) + DROP_W'(1)))
        else $error("exhausted allocation did not bump drop counter");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_pop) |=> (r_state == S_DONE))
        else $error("pending result left before output register freed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_found) |=>
        ((32'(r_cur_s) < SMALL_SLOTS) && (32'(r_cur_m) < MEDIUM_SLOTS)))
        else $error("next-fit cursor outside its pool");

endmodule
`default_nettype wire

// ===== design/refcounted_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reference-counted slot pool allocator
// Two slot pools with per-slot reference counts; next-fit allocation that
// falls back from the small pool to the medium pool.
//
//   channel   direction  handshake           payload
//   request   in         push / full         req_type, pool_select, slot_number
//   result    out        empty / pop         status, granted_pool, granted_slot,
//                                            count_after, became_free, drop_total
//
// Retain, release and force free pass through dispatch, count read-modify-write
// and result hand-off; the engine takes the queue head whenever it is idle.
// Allocation scans the small pool from its cursor and, when that pool is full,
// the medium pool from its own cursor; the scan checks 8 slots per cycle. A
// result left waiting holds the engine in hand-off; the two-entry front queue
// then fills and raises full.
// Synchronous reset marks every slot free at once; no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_slot_pool_allocator
    import rspa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [1:0]              i_req_type,
    input  wire logic                    i_pool_select,
    input  wire logic [SLOT_PORT_W-1:0]  i_slot_number,
    output logic                         empty,
    input  wire logic                    pop,
    output logic [2:0]                   o_status,
    output logic                         o_granted_pool,
    output logic [SLOT_PORT_W-1:0]       o_granted_slot,
    output logic [COUNT_PORT_W-1:0]      o_count_after,
    output logic                         o_became_free,
    output logic [DROP_W-1:0]            o_drop_total
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_res_valid;
    t_res w_res;

    rspa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_pool_select (i_pool_select),
        .i_slot_number (i_slot_number),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    rspa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_pop       (pop)
    );

    assign empty          = !w_res_valid;
    assign o_status       = w_res.status;
    assign o_granted_pool = w_res.pool;
    assign o_granted_slot = w_res.slot;
    assign o_count_after  = w_res.count;
    assign o_became_free  = w_res.freed;
    assign o_drop_total   = w_res.drop;

endmodule
`default_nettype wire

// ===== verif/refcounted_slot_pool_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Sends allocate, retain, release and force free requests through the queue
// style ports, tracks slot counts, cursors and the drop total alongside the
// block, and checks every result field in request order. Covers corner
// cases, pool exhaustion, count saturation, a long result stall and mixed
// traffic, with random gaps on both sides.
// ----------------------------------------------------------------------------
module refcounted_slot_pool_allocator_test;
    import rspa_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 24;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          COUNT_MAX      = (1 << COUNT_BITS) - 1;
    localparam logic [31:0] DROP_MAX       = 32'hFFFF_FFFF;

    typedef enum {POP_ALWAYS, POP_MOSTLY, POP_RANDOM, POP_SPARSE} t_pop_mode;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push    = 1'b0;
    logic                    pop     = 1'b0;
    t_req                    req_type = REQ_ALLOC;
    logic                    pool_sel = 1'b0;
    logic [SLOT_PORT_W-1:0]  slot_num = '0;
    logic                    full;
    logic                    empty;
    logic [2:0]              o_status;
    logic                    o_granted_pool;
    logic [SLOT_PORT_W-1:0]  o_granted_slot;
    logic [COUNT_PORT_W-1:0] o_count_after;
    logic                    o_became_free;
    logic [DROP_W-1:0]       o_drop_total;

    // mirror of the block's slot state
    logic [COUNT_BITS-1:0] small_cnt [SMALL_SLOTS];
    logic [COUNT_BITS-1:0] medium_cnt [MEDIUM_SLOTS];
    int                    small_cursor = 0;
    int                    medium_cursor = 0;
    logic [DROP_W-1:0]     drop_tally = '0;

    t_res pending_grants [$];
    int   error_count   = 0;
    int   burst_left    = 1;
    bit   steady_feed   = 1'b0;
    int   hold_request  = 0;

    refcounted_slot_pool_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (req_type),
        .i_pool_select  (pool_sel),
        .i_slot_number  (slot_num),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_granted_pool (o_granted_pool),
        .o_granted_slot (o_granted_slot),
        .o_count_after  (o_count_after),
        .o_became_free  (o_became_free),
        .o_drop_total   (o_drop_total)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the mirrored state and return the result it gives.
    function automatic t_res predict_grant(t_req req, logic pool, logic [SLOT_PORT_W-1:0] slot);
        t_res                  r;
        int                    idx;
        int                    size;
        bit                    found;
        logic [COUNT_BITS-1:0] c;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        if (req == REQ_ALLOC) begin
            for (int i = 0; i < SMALL_SLOTS; i++) begin
                idx = (small_cursor + i) % SMALL_SLOTS;
                if (!found && small_cnt[idx] == 0) begin
                    found = 1'b1;
                    small_cnt[idx] = COUNT_BITS'(1);
                    r.pool = 1'b0;
                    r.slot = SLOT_PORT_W'(idx);
                    r.count = COUNT_PORT_W'(1);
                    small_cursor = (idx + 1) % SMALL_SLOTS;
                end
            end
            for (int i = 0; i < MEDIUM_SLOTS; i++) begin
                idx = (medium_cursor + i) % MEDIUM_SLOTS;
                if (!found && medium_cnt[idx] == 0) begin
                    found = 1'b1;
                    medium_cnt[idx] = COUNT_BITS'(1);
                    r.pool = 1'b1;
                    r.slot = SLOT_PORT_W'(idx);
                    r.count = COUNT_PORT_W'(1);
                    medium_cursor = (idx + 1) % MEDIUM_SLOTS;
                end
            end
            if (!found) begin
                r.status = ST_EXHAUST;
                if (drop_tally != DROP_MAX)
                    drop_tally++;
            end
        end else begin
            r.pool = pool;
            r.slot = slot;
            size = pool ? MEDIUM_SLOTS : SMALL_SLOTS;
            if (slot >= size) begin
                r.status = ST_RANGE;
            end else begin
                c = pool ? medium_cnt[slot] : small_cnt[slot];
                case (req)
                    REQ_RETAIN: begin
                        if (c == COUNT_MAX)
                            r.status = ST_SAT;
                        else
                            c++;
                    end
                    REQ_RELEASE: begin
                        if (c == 0) begin
                            r.status = ST_UNDER;
                        end else begin
                            c--;
                            r.freed = (c == 0);
                        end
                    end
                    default: begin
                        r.freed = (c != 0);
                        c = '0;
                    end
                endcase
                if (pool)
                    medium_cnt[slot] = c;
                else
                    small_cnt[slot] = c;
                r.count = c;
            end
        end
        r.drop = drop_tally;
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then log its expected result.
    // Push stays high for back-to-back requests; drop it only for a gap.
    task automatic send_request(t_req req, logic pool, logic [SLOT_PORT_W-1:0] slot);
        int gap;
        push     <= 1'b1;
        req_type <= req;
        pool_sel <= pool;
        slot_num <= slot;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        pending_grants.push_back(predict_grant(req, pool, slot));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 12);
            if (!steady_feed && gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_alloc();
        send_request(REQ_ALLOC, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    endtask

    // Pick a slot that is in use if one turns up quickly, else any valid slot.
    task automatic pick_busy_slot(output logic pool, output logic [SLOT_PORT_W-1:0] slot);
        for (int tries = 0; tries < 24; tries++) begin
            pool = 1'($urandom_range(0, 1));
            slot = SLOT_PORT_W'(pool ? $urandom_range(0, MEDIUM_SLOTS - 1)
                                     : $urandom_range(0, SMALL_SLOTS - 1));
            if ((pool ? medium_cnt[slot] : small_cnt[slot]) != 0)
                return;
        end
    endtask

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // Check each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_grants.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result with no request outstanding: status %0d slot %0d",
                             o_status, o_granted_slot);
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_granted_pool !== want.pool)
                    note_mismatch("granted_pool", want.pool, o_granted_pool);
                if (o_granted_slot !== want.slot)
                    note_mismatch("granted_slot", want.slot, o_granted_slot);
                if (o_count_after !== want.count)
                    note_mismatch("count_after", want.count, o_count_after);
                if (o_became_free !== want.freed)
                    note_mismatch("became_free", want.freed, o_became_free);
                if (o_drop_total !== want.drop)
                    note_mismatch("drop_total", want.drop, o_drop_total);
            end
        end
    end

    // Result side: stall on a rotating pattern, or hold off when asked.
    always @(posedge i_clk) begin
        static t_pop_mode pop_mode  = POP_ALWAYS;
        static int        mode_left = 0;
        static int        hold_left = 0;
        static int        phase     = 0;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                pop_mode  = t_pop_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 150);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (pop_mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_MOSTLY: pop <= (phase % 4) != 0;
                    POP_RANDOM: pop <= 1'($urandom_range(0, 1));
                    default:    pop <= (phase % 8) == 0;
                endcase
            end
        end
    end

    // End the run if nothing moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("refcounted_slot_pool_allocator_test failed");
        $finish;
    end

    task automatic test_directed_corners();
        send_request(REQ_RELEASE, 1'b0, 6'd0);   // release of a free slot
        send_request(REQ_FREE,    1'b0, 6'd5);   // force free of a free slot
        send_request(REQ_RETAIN,  1'b0, 6'd63);  // retain of a free slot
        send_request(REQ_ALLOC,   1'b0, 6'd0);
        send_request(REQ_ALLOC,   1'b1, 6'd63);  // addressed fields ignored
        send_request(REQ_RETAIN,  1'b1, 6'd31);
        send_request(REQ_RETAIN,  1'b1, 6'd32);  // out of range in medium pool
        send_request(REQ_RELEASE, 1'b1, 6'd63);
        send_request(REQ_FREE,    1'b1, 6'd40);
        send_request(REQ_RETAIN,  1'b0, 6'd0);
        send_request(REQ_RELEASE, 1'b0, 6'd0);
        send_request(REQ_RELEASE, 1'b0, 6'd0);   // count reaches zero
        send_request(REQ_FREE,    1'b0, 6'd1);
        send_request(REQ_FREE,    1'b0, 6'd63);
        send_request(REQ_RELEASE, 1'b1, 6'd31);
        send_request(REQ_ALLOC,   1'b0, 6'd0);   // next fit skips freed slot 0
        send_request(REQ_ALLOC,   1'b1, 6'd42);
        send_request(REQ_RELEASE, 1'b0, 6'd42);
    endtask

    task automatic test_pool_exhaustion();
        logic                   pool;
        logic [SLOT_PORT_W-1:0] slot;
        repeat (100) send_alloc();
        // punch holes and refill so the cursors wrap
        repeat (10) begin
            pick_busy_slot(pool, slot);
            send_request($urandom_range(0, 1) ? REQ_FREE : REQ_RELEASE, pool, slot);
        end
        repeat (12) send_alloc();
    endtask

    task automatic test_count_saturation();
        logic                   pool;
        logic [SLOT_PORT_W-1:0] slot;
        pool = 1'($urandom_range(0, 1));
        slot = SLOT_PORT_W'(pool ? $urandom_range(0, MEDIUM_SLOTS - 1)
                                 : $urandom_range(0, SMALL_SLOTS - 1));
        repeat (COUNT_MAX + 3) send_request(REQ_RETAIN, pool, slot);
        repeat (3) send_request(REQ_RELEASE, pool, slot);
        send_request(REQ_FREE, pool, slot);
        send_request(REQ_RELEASE, pool, slot);
    endtask

    task automatic test_result_backpressure();
        logic                   pool;
        logic [SLOT_PORT_W-1:0] slot;
        hold_request = HOLD_CYCLES;
        steady_feed  = 1'b1;
        repeat (24) begin
            if ($urandom_range(0, 1)) begin
                send_alloc();
            end else begin
                pick_busy_slot(pool, slot);
                send_request(REQ_RETAIN, pool, slot);
            end
        end
        steady_feed = 1'b0;
    endtask

    task automatic test_mixed_traffic(int n, int alloc_pct);
        int                     pick;
        logic                   pool;
        logic [SLOT_PORT_W-1:0] slot;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_request(t_req'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             6'($urandom_range(0, 63)));
            end else if (pick < 10 + alloc_pct) begin
                send_alloc();
            end else begin
                pick_busy_slot(pool, slot);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_request(REQ_RETAIN, pool, slot);
                else if (pick < 85)
                    send_request(REQ_RELEASE, pool, slot);
                else
                    send_request(REQ_FREE, pool, slot);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SMALL_SLOTS; i++)
            small_cnt[i] = '0;
        for (int i = 0; i < MEDIUM_SLOTS; i++)
            medium_cnt[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_pool_exhaustion();
        test_count_saturation();
        test_result_backpressure();
        test_mixed_traffic(330, 45);
        test_mixed_traffic(300, 20);
        push <= 1'b0;

        while (pending_grants.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("refcounted_slot_pool_allocator_test passed");
        else
            $display("refcounted_slot_pool_allocator_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rspa_pkg.sv
design/rspa_front.sv
design/rspa_back.sv
design/refcounted_slot_pool_allocator.sv
verif/refcounted_slot_pool_allocator_test.sv
